// ----- rtl/ush_pkg.sv -----
// Shared constants and the controller-to-datapath command type for the string hash.
package ush_pkg;

    localparam int BYTE_W     = 8;
    localparam int HASH_W     = 16;
    // Largest dividend is 46339 * 46339 + 255, which stays below 2**31
    localparam int DVD_W      = 31;
    localparam int STEP_COUNT = DVD_W;
    localparam int CNT_W      = $clog2(STEP_COUNT);

    localparam logic [HASH_W-1:0] INIT_MULT  = HASH_W'(31415);
    localparam logic [HASH_W-1:0] MULT_STEP  = HASH_W'(27183);
    localparam logic [HASH_W-1:0] SIZE_MIN   = HASH_W'(2);
    localparam logic [HASH_W-1:0] SIZE_MAX   = HASH_W'(46340);
    localparam logic [HASH_W-1:0] SIZE_RESET = HASH_W'(1021);

    typedef struct packed {
        logic load;    // latch byte and size, form both products
        logic start;   // load the remainder units
        logic step;    // one remainder bit
        logic commit;  // write back hash and multiplier
        logic emit;    // string end: move hash to output, restart
    } ush_cmd_t;

endpackage

// ----- rtl/ush_div.sv -----
// Restoring remainder unit: one dividend bit per step.
module ush_div
(
    input  logic                        clk,
    input  logic                        start,
    input  logic                        step,
    input  logic [ush_pkg::DVD_W-1:0]   dividend,
    input  logic [ush_pkg::HASH_W-1:0]  divisor,
    output logic [ush_pkg::HASH_W-1:0]  remainder
);
    import ush_pkg::*;

    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  dvd_next;
    logic [HASH_W-1:0] rem_reg;
    logic [HASH_W-1:0] rem_next;
    logic [HASH_W:0]   shifted;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DVD_W-1]};
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (step)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, divisor})
                rem_next = HASH_W'(shifted - {1'b0, divisor});
            else
                rem_next = shifted[HASH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;

endmodule

// ----- rtl/ush_dp.sv -----
// Datapath: size register, hash state, products, remainder units and slot register.
module ush_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ush_pkg::ush_cmd_t           cmd,
    input  logic                        cfg_we,
    input  logic [ush_pkg::HASH_W-1:0]  cfg_data,
    input  logic [ush_pkg::BYTE_W-1:0]  char_byte,
    output logic [ush_pkg::HASH_W-1:0]  slot
);
    import ush_pkg::*;

    logic [HASH_W-1:0] table_size_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mult_reg;
    logic [HASH_W-1:0] mult_next;
    logic [HASH_W-1:0] size_reg;
    logic [HASH_W-1:0] size_eff;
    logic [DVD_W-1:0]  prod_h_reg;
    logic [DVD_W-1:0]  prod_a_reg;
    logic [HASH_W-1:0] slot_reg;
    logic [HASH_W-1:0] rem_h;
    logic [HASH_W-1:0] rem_a;

    // Clamp the size so that neither modulus is zero and no product overflows
    always_comb
    begin
        if (table_size_reg < SIZE_MIN)
            size_eff = SIZE_MIN;
        else if (table_size_reg > SIZE_MAX)
            size_eff = SIZE_MAX;
        else
            size_eff = table_size_reg;
    end

    always_comb
    begin
        hash_next = hash_reg;
        mult_next = mult_reg;
        if (cmd.emit)
        begin
            hash_next = '0;
            mult_next = INIT_MULT;
        end
        else if (cmd.commit)
        begin
            hash_next = rem_h;
            mult_next = rem_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
            hash_reg       <= '0;
            mult_reg       <= INIT_MULT;
        end
        else
        begin
            if (cfg_we)
                table_size_reg <= cfg_data;
            hash_reg <= hash_next;
            mult_reg <= mult_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            size_reg   <= size_eff;
            prod_h_reg <= DVD_W'(32'(mult_reg) * 32'(hash_reg) + 32'(char_byte));
            prod_a_reg <= DVD_W'(32'(mult_reg) * 32'(MULT_STEP));
        end
        if (cmd.emit)
            slot_reg <= hash_reg;
    end

    ush_div u_div_hash
    (
        .clk       (clk),
        .start     (cmd.start),
        .step      (cmd.step),
        .dividend  (prod_h_reg),
        .divisor   (size_reg),
        .remainder (rem_h)
    );

    ush_div u_div_mult
    (
        .clk       (clk),
        .start     (cmd.start),
        .step      (cmd.step),
        .dividend  (prod_a_reg),
        .divisor   (size_reg - HASH_W'(1)),
        .remainder (rem_a)
    );

    assign slot = slot_reg;

endmodule

// ----- rtl/ush_ctrl.sv -----
// Controller: sequences one byte through products, remainder steps and write-back, or emits the slot on a zero byte.
module ush_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ush_pkg::BYTE_W-1:0]  in_byte,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ush_pkg::ush_cmd_t           cmd
);
    import ush_pkg::*;

    typedef enum logic [1:0] {IDLE, PROD, DIVIDE, COMMIT} state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;

    // Take a byte only when a terminator could also land in the slot register
    assign in_ready = (state_reg == IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (in_byte == '0)
                    begin
                        cmd.emit       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = PROD;
                    end
                end
            end
            PROD:
            begin
                cmd.start  = 1'b1;
                cnt_next   = '0;
                state_next = DIVIDE;
            end
            DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEP_COUNT - 1))
                    state_next = COMMIT;
            end
            COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/universal_string_hash.sv -----
// Universal string hash: from accept to next ready, a nonzero byte passes through the product
// load, a divider load, the remainder steps shared by both moduli, and a write-back.
// A zero byte's slot is offered on the cycle after the byte is taken.
// The bit-serial remainder units finish each byte before the next byte is taken.
// Reset: table_size 1021, hash 0, multiplier 31415, no transaction pending.
module universal_string_hash
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] char_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,   // [15:0] slot
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [15:0]                 cfg_data        // [15:0] table_size
);
    import ush_pkg::*;

    ush_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ush_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    ush_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .char_byte (s_axis_tdata),
        .slot      (m_axis_tdata)
    );

endmodule
